>>> sv/apqs_pkg.sv
// Shared types, codes and sizes for the aging priority queue scheduler.
package apqs_pkg;

    localparam int TableDepth = 16;
    localparam int SlotW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_AGE     = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_MOB_THR   = 3'd0,
        CFG_LAT_THR   = 3'd1,
        CFG_BAT_THR   = 3'd2,
        CFG_MOB_BOOST = 3'd3,
        CFG_LAT_BOOST = 3'd4,
        CFG_BAT_BOOST = 3'd5,
        CFG_FLOOR     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_id;
        logic [7:0]  initial_priority;
        logic [7:0]  mobility;
        logic [7:0]  latency_sensitivity;
        logic [15:0] battery_life;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        granted;
        logic [15:0] granted_id;
        logic [7:0]  granted_priority;
    } t_out;

    typedef struct packed {
        logic [7:0]  mob_thr;
        logic [7:0]  lat_thr;
        logic [15:0] bat_thr;
        logic [3:0]  mob_boost;
        logic [3:0]  lat_boost;
        logic [3:0]  bat_boost;
        logic [7:0]  prio_floor;
    } t_cfg;

    typedef struct packed {
        logic battery;
        logic latency;
        logic mobile;
    } t_flags;

    typedef struct packed {
        t_action     action;
        logic [15:0] task_id;
        logic [7:0]  prio;
        t_flags      flags;
    } t_cmd;

endpackage

>>> sv/apqs_front.sv
// Front end: takes requests, derives context flags, buffers commands for the back end.
module apqs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  apqs_pkg::t_cfg i_cfg,
    input  logic           i_push,
    input  apqs_pkg::t_in  i_task,
    output logic           o_full,
    output apqs_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_take
);
    import apqs_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       cmd_in;
    logic       push_ok;
    logic       take_ok;

    always_comb begin
        cmd_in.action        = t_action'(i_task.action);
        cmd_in.task_id       = i_task.task_id;
        cmd_in.prio          = i_task.initial_priority;
        cmd_in.flags.mobile  = i_task.mobility > i_cfg.mob_thr;
        cmd_in.flags.latency = i_task.latency_sensitivity > i_cfg.lat_thr;
        cmd_in.flags.battery = i_task.battery_life < i_cfg.bat_thr;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (take_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, take_ok};
        end
    end

endmodule

>>> sv/apqs_back.sv
// Back end: task table, aging scan with best-slot search, result register.
module apqs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  apqs_pkg::t_cfg i_cfg,
    input  apqs_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_take,
    output apqs_pkg::t_out o_res,
    output logic           o_res_valid,
    input  logic           i_res_pop
);
    import apqs_pkg::*;

    t_bstate               r_state;
    t_bstate               n_state;
    t_cmd                  r_cmd;
    t_status               r_status;
    logic [SlotW-1:0]      r_idx;
    logic                  r_best_found;
    logic [SlotW-1:0]      r_best_idx;
    logic [7:0]            r_best_prio;
    logic [15:0]           r_best_age;
    logic [15:0]           r_best_id;
    logic [TableDepth-1:0] r_valid;
    logic [15:0]           r_task_id [TableDepth];
    logic [7:0]            r_prio    [TableDepth];
    t_flags                r_flags   [TableDepth];
    logic [15:0]           r_order   [TableDepth];
    logic [15:0]           r_ins_cnt;
    t_out                  r_out;
    logic                  r_out_valid;

    logic             out_free;
    logic             any_valid;
    logic             has_free;
    logic [SlotW-1:0] free_idx;
    logic             last_idx;
    logic [7:0]       cur_prio;
    t_flags           cur_flags;
    logic [5:0]       dec;
    logic [8:0]       diff;
    logic [7:0]       sub_prio;
    logic [7:0]       new_prio;
    logic [15:0]      cur_age;
    logic             better;
    logic             do_insert;
    logic             scan_wr;
    logic             scan_sel;
    logic             out_load;
    logic             grant;
    t_out             res_next;

    assign out_free  = !r_out_valid || i_res_pop;
    assign any_valid = |r_valid;
    assign has_free  = ~&r_valid;
    assign last_idx  = (r_idx == SlotW'(TableDepth - 1));

    // lowest numbered free slot
    always_comb begin
        free_idx = '0;
        for (int i = TableDepth - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SlotW'(i);
            end
        end
    end

    // aging of the slot under the scan pointer
    always_comb begin
        cur_prio  = r_prio[r_idx];
        cur_flags = r_flags[r_idx];
        dec = ({2'b00, i_cfg.mob_boost} & {6{cur_flags.mobile}})
            + ({2'b00, i_cfg.lat_boost} & {6{cur_flags.latency}})
            + ({2'b00, i_cfg.bat_boost} & {6{cur_flags.battery}});
        diff     = {1'b0, cur_prio} - {3'b000, dec};
        sub_prio = diff[8] ? 8'd0 : diff[7:0];
        new_prio = (sub_prio < i_cfg.prio_floor) ? i_cfg.prio_floor : sub_prio;
        cur_age  = r_ins_cnt - r_order[r_idx];
        // ties go to the larger age, i.e. the older insert
        better   = !r_best_found || (new_prio < r_best_prio)
                || ((new_prio == r_best_prio) && (cur_age > r_best_age));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    if ((i_cmd.action == ACT_DEQUEUE && any_valid)
                            || i_cmd.action == ACT_AGE) begin
                        n_state = BS_SCAN;
                    end else begin
                        n_state = BS_DONE;
                    end
                end
            end
            BS_SCAN: begin
                if (last_idx) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = (r_state == BS_IDLE) && i_cmd_valid;
        do_insert  = o_cmd_take && (i_cmd.action == ACT_INSERT) && has_free;
        scan_wr    = (r_state == BS_SCAN) && r_valid[r_idx];
        scan_sel   = scan_wr && (r_cmd.action == ACT_DEQUEUE) && better;
        out_load   = (r_state == BS_DONE) && out_free;
        grant      = out_load && r_best_found;
        if (r_best_found) begin
            res_next.status           = ST_OK;
            res_next.granted          = 1'b1;
            res_next.granted_id       = r_best_id;
            res_next.granted_priority = r_best_prio;
        end else begin
            res_next.status           = r_status;
            res_next.granted          = 1'b0;
            res_next.granted_id       = 16'd0;
            res_next.granted_priority = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_valid      <= '0;
            r_ins_cnt    <= 16'd0;
            r_out_valid  <= 1'b0;
            r_best_found <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            if (do_insert) begin
                r_valid[free_idx] <= 1'b1;
                r_ins_cnt         <= r_ins_cnt + 16'd1;
            end
            if (grant) begin
                r_valid[r_best_idx] <= 1'b0;
            end
            if (o_cmd_take) begin
                r_best_found <= 1'b0;
                r_idx        <= '0;
            end else begin
                if (scan_sel) begin
                    r_best_found <= 1'b1;
                end
                if (r_state == BS_SCAN) begin
                    r_idx <= r_idx + SlotW'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
            if (i_cmd.action == ACT_INSERT && !has_free) begin
                r_status <= ST_FULL;
            end else if (i_cmd.action == ACT_DEQUEUE && !any_valid) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (do_insert) begin
            r_task_id[free_idx] <= i_cmd.task_id;
            r_prio[free_idx]    <= i_cmd.prio;
            r_flags[free_idx]   <= i_cmd.flags;
            r_order[free_idx]   <= r_ins_cnt;
        end
        if (scan_wr) begin
            r_prio[r_idx] <= new_prio;
        end
        if (scan_sel) begin
            r_best_idx  <= r_idx;
            r_best_prio <= new_prio;
            r_best_age  <= cur_age;
            r_best_id   <= r_task_id[r_idx];
        end
        if (out_load) begin
            r_out <= res_next;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

`ifndef SYNTHESIS
    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grant |=> !r_valid[$past(r_best_idx)])
        else $error("granted slot still valid after transfer");

    a_best_is_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DONE && r_best_found) |-> r_valid[r_best_idx])
        else $error("selected slot not valid");

    a_best_only_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DONE && r_best_found) |-> r_cmd.action == ACT_DEQUEUE)
        else $error("grant on a non-dequeue command");

    a_scan_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SCAN) |-> (r_cmd.action == ACT_DEQUEUE || r_cmd.action == ACT_AGE))
        else $error("scan running for insert or no-op");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == BS_IDLE))
        else $error("result load did not complete");
`endif

endmodule

>>> sv/aging_priority_queue_scheduler_core.sv
// Top level: configuration registers, front end and back end of the scheduler.
//
// Requests enter through push/full as a t_in item: insert a task, age all tasks then
// dequeue the best one, or age only. Every request yields exactly one t_out result,
// presented while empty is low and removed with pop. Results come out in request order.
// Configuration: a write with i_cfg_we high loads register i_cfg_idx from i_cfg_wdata;
// unknown indexes are ignored. Write only while no request is outstanding.
// The front end registers each request with its context flags in a two-entry queue,
// so a new request is taken while the back end is busy. The back end walks the table
// one slot per cycle with a single aging and compare unit.
// Per request the back end goes from idle to done and back to idle: insert, empty dequeue
// and no-op go straight to done; age and dequeue pass first through the slot scan over
// all TableDepth slots. The result register loads in the done state once it is free,
// and the back end takes no new request before it is back in idle.
// When pop stays low the result register holds; the back end finishes its current
// request and then waits, and full rises once the command queue holds two requests.
// Reset empties the table, the command queue and the result register, clears the
// insert counter and loads the default thresholds, boosts and floor.
module aging_priority_queue_scheduler_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  apqs_pkg::t_in  i_task,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output apqs_pkg::t_out o_result,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_wdata
);
    import apqs_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;
    logic res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mob_thr    <= 8'd179;
            r_cfg.lat_thr    <= 8'd204;
            r_cfg.bat_thr    <= 16'd256;
            r_cfg.mob_boost  <= 4'd2;
            r_cfg.lat_boost  <= 4'd3;
            r_cfg.bat_boost  <= 4'd1;
            r_cfg.prio_floor <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MOB_THR:   r_cfg.mob_thr    <= i_cfg_wdata[7:0];
                CFG_LAT_THR:   r_cfg.lat_thr    <= i_cfg_wdata[7:0];
                CFG_BAT_THR:   r_cfg.bat_thr    <= i_cfg_wdata;
                CFG_MOB_BOOST: r_cfg.mob_boost  <= i_cfg_wdata[3:0];
                CFG_LAT_BOOST: r_cfg.lat_boost  <= i_cfg_wdata[3:0];
                CFG_BAT_BOOST: r_cfg.bat_boost  <= i_cfg_wdata[3:0];
                CFG_FLOOR:     r_cfg.prio_floor <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    apqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_task      (i_task),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    apqs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .o_res       (o_result),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule
